>>> src/polyline_arc_length_resampler_core_defines.svh
// Assertion macros shared by the resampler checker.
// Depends on nothing; included by src/arl_checker.sv.
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_CORE_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ARL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/arl_pkg.sv
// Types and fixed constants of the arc-length resampler.
// Depends on nothing; used by arl_seglen, arl_div, arl_lerp and the resampler core.
package arl_pkg;

    localparam int COORD_W   = 32;
    localparam int SPACING_W = 31;
    localparam int MAG_W     = COORD_W + 1;     // |cur - prev|
    localparam int SQ_W      = 2 * MAG_W;       // sum of three squares fits
    localparam int ROOT_W    = MAG_W;           // floor sqrt of SQ_W bits
    localparam int WFRAC     = 30;              // fraction bits of the weight
    localparam int ACC_W     = MAG_W + WFRAC;

    localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(65536);

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [MAG_W-1:0]   t_mag;

    // Handshake-free status of an iterative unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

>>> src/arl_seglen.sv
// Segment length unit: bit-serial sum of squares, then a digit-by-digit square root.
// Depends on arl_pkg.
module arl_seglen (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  arl_pkg::t_mag                   i_mag_x,
    input  arl_pkg::t_mag                   i_mag_y,
    input  arl_pkg::t_mag                   i_mag_z,
    output arl_pkg::t_unit_stat             o_stat,
    output logic [arl_pkg::ROOT_W-1:0]      o_len
);
    localparam int RW   = arl_pkg::ROOT_W + 3;
    localparam int CNTW = $clog2(arl_pkg::MAG_W + 1);

    arl_pkg::t_mag                  r_mx, r_my, r_mz;
    arl_pkg::t_mag                  r_bx, r_by, r_bz;
    logic [arl_pkg::SQ_W-1:0]       r_sq;
    logic [RW-1:0]                  r_rem;
    logic [arl_pkg::ROOT_W-1:0]     r_root;
    logic [CNTW-1:0]                r_cnt;
    logic                           r_busy;
    logic                           r_phase;

    logic [arl_pkg::SQ_W-1:0] n_sq;
    logic [RW-1:0]            n_trial, n_t;
    logic                     n_ge;

    always_comb begin
        n_sq = (r_sq << 1)
             + (r_bx[arl_pkg::MAG_W-1] ? arl_pkg::SQ_W'(r_mx) : '0)
             + (r_by[arl_pkg::MAG_W-1] ? arl_pkg::SQ_W'(r_my) : '0)
             + (r_bz[arl_pkg::MAG_W-1] ? arl_pkg::SQ_W'(r_mz) : '0);
        n_t     = {r_rem[RW-3:0], r_sq[arl_pkg::SQ_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = (n_t >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= CNTW'(arl_pkg::MAG_W);
            r_mx <= i_mag_x; r_my <= i_mag_y; r_mz <= i_mag_z;
            r_bx <= i_mag_x; r_by <= i_mag_y; r_bz <= i_mag_z;
            r_sq <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_sq <= n_sq;
                r_bx <= r_bx << 1;
                r_by <= r_by << 1;
                r_bz <= r_bz << 1;
                if (r_cnt == CNTW'(1)) begin
                    r_phase <= 1'b1;
                    r_cnt   <= CNTW'(arl_pkg::ROOT_W);
                    r_rem   <= '0;
                    r_root  <= '0;
                end else begin
                    r_cnt <= r_cnt - CNTW'(1);
                end
            end else begin
                r_rem  <= n_ge ? (n_t - n_trial) : n_t;
                r_root <= {r_root[arl_pkg::ROOT_W-2:0], n_ge};
                r_sq   <= r_sq << 2;
                r_cnt  <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && r_phase && (r_cnt == CNTW'(1));
    assign o_len       = r_root;

endmodule

>>> src/arl_div.sv
// Restoring divider, one quotient bit per cycle, with a preset starting remainder.
// Depends on arl_pkg.
module arl_div #(
    parameter int W = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [W-1:0]                i_rem0,
    input  logic [W-1:0]                i_num,
    input  logic [W-1:0]                i_den,
    input  logic [$clog2(W+1)-1:0]      i_steps,
    output arl_pkg::t_unit_stat         o_stat,
    output logic                        o_step,
    output logic                        o_qbit,
    output logic [W-1:0]                o_quo,
    output logic [W-1:0]                o_rem
);
    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    r_rem, r_num, r_den, r_quo;
    logic [CNTW-1:0] r_cnt;

    logic [W:0] n_t;
    logic       n_ge;

    always_comb begin
        n_t  = {r_rem, r_num[W-1]};
        n_ge = (n_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_steps;
            r_rem <= i_rem0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNTW'(1);
            r_rem <= n_ge ? W'(n_t - {1'b0, r_den}) : W'(n_t);
            r_num <= r_num << 1;
            r_quo <= {r_quo[W-2:0], n_ge};
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = (r_cnt == CNTW'(1));
    assign o_step      = (r_cnt != '0);
    assign o_qbit      = n_ge;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

>>> src/arl_lerp.sv
// Interpolator: three Horner accumulators fed by the weight bits, most significant first.
// Depends on arl_pkg.
module arl_lerp (
    input  logic                i_clk,
    input  logic                i_clr,
    input  logic                i_step,
    input  logic                i_qbit,
    input  arl_pkg::t_mag       i_mag  [3],
    input  logic                i_neg  [3],
    input  arl_pkg::t_coord     i_base [3],
    output arl_pkg::t_coord     o_pt   [3]
);
    localparam int AW = arl_pkg::ACC_W;
    localparam int CW = arl_pkg::COORD_W;

    logic [AW-1:0] r_acc [3];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (i_clr) begin
                r_acc[a] <= '0;
            end else if (i_step) begin
                r_acc[a] <= (r_acc[a] << 1) + (i_qbit ? AW'(i_mag[a]) : '0);
            end
        end
    end

    always_comb begin
        logic [AW-1:0]   rnd;
        logic [CW+1:0]   off;
        logic [CW+1:0]   base;
        for (int a = 0; a < 3; a++) begin
            rnd  = r_acc[a] + (AW'(1) << (arl_pkg::WFRAC - 1));
            off  = (CW + 2)'(rnd >> arl_pkg::WFRAC);
            base = {{2{i_base[a][CW-1]}}, i_base[a]};
            o_pt[a] = CW'(i_neg[a] ? (base - off) : (base + off));
        end
    end

endmodule

>>> src/polyline_arc_length_resampler_core.sv
// Uniform arc-length resampler for 3-D polylines, signed Q15.16 coordinates.
// Depends on arl_pkg, arl_seglen, arl_div and arl_lerp.
//
// Usage. Vertices enter on the input channel (i_in_valid / o_in_ready) as one
// transaction each; i_first_point starts a new curve. Samples leave on the output
// channel (o_out_valid / i_out_ready), one transaction per sample, with
// o_last_of_run on the final sample of a vertex and o_run_truncated on every
// sample of a segment that held more than MAX_SAMPLES_PER_SEGMENT samples.
// i_cfg_we writes the sample spacing; zero selects pass-through.
// Flow. The block handles one vertex at a time. A curve start passes ST_DECIDE;
// a pass-through vertex goes on to ST_PASS. A segment computes its squares and
// square root in the length unit (ST_LEN), then ST_ACC and ST_CHK, then the
// serial divider counts the samples with LENGTH_WIDTH quotient bits, then a
// planning step, then per sample 30 weight bits from the same divider, fed at
// once into the interpolator, and the load of the output register. ST_FIN
// closes the segment; a segment without samples skips the divider.
// Reset clears the previous vertex, both arc lengths and the curve flag, and
// sets the spacing to 1.0. When the receiver stalls, the pending sample waits
// in the output register and the next sample waits in its emit step.
module polyline_arc_length_resampler_core #(
    parameter int MAX_SAMPLES_PER_SEGMENT = 64,
    parameter int LENGTH_WIDTH            = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arl_pkg::SPACING_W-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [arl_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [arl_pkg::COORD_W-1:0]  i_point_y,
    input  logic signed [arl_pkg::COORD_W-1:0]  i_point_z,
    input  logic                                i_first_point,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [arl_pkg::COORD_W-1:0]  o_sample_x,
    output logic signed [arl_pkg::COORD_W-1:0]  o_sample_y,
    output logic signed [arl_pkg::COORD_W-1:0]  o_sample_z,
    output logic                                o_last_of_run,
    output logic                                o_run_truncated
);
    localparam int LW   = LENGTH_WIDTH;
    localparam int SW   = ((LW > arl_pkg::ROOT_W) ? LW : arl_pkg::ROOT_W) + 1;
    localparam int CW   = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam int DCW  = $clog2(LW + 1);
    localparam logic [SW-1:0] LEN_MAX_X = {{(SW - LW){1'b0}}, {LW{1'b1}}};
    localparam logic [LW-1:0] LEN_MAX   = {LW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_PASS, ST_LEN, ST_ACC, ST_CHK,
        ST_KDIV, ST_PLAN, ST_WDIV, ST_EMIT, ST_FIN
    } t_state;

    t_state                         r_state;
    logic [arl_pkg::SPACING_W-1:0]  r_spacing;
    arl_pkg::t_coord                r_cur  [3];
    arl_pkg::t_coord                r_prev [3];
    logic                           r_first;
    logic                           r_started;
    logic [LW-1:0]                  r_lsf, r_nsp, r_next_len, r_nsp_new, r_off;
    logic                           r_hit, r_trunc;
    logic [CW-1:0]                  r_cnt;
    arl_pkg::t_mag                  r_mag [3];
    logic                           r_neg [3];

    logic                           r_out_valid, r_out_last, r_out_trunc;
    arl_pkg::t_coord                r_out [3];

    // Unit wiring.
    arl_pkg::t_unit_stat            seg_stat, div_stat;
    logic [arl_pkg::ROOT_W-1:0]     seg_len;
    logic                           seg_start;
    logic                           div_load, div_step, div_qbit;
    logic [LW-1:0]                  div_rem0, div_num, div_den, div_quo, div_rem;
    logic [DCW-1:0]                 div_steps;
    logic                           lerp_clr;
    arl_pkg::t_coord                lerp_pt [3];

    // Combinational helpers.
    arl_pkg::t_mag                  n_mag [3];
    logic                           n_neg [3];
    logic [arl_pkg::MAG_W-1:0]      n_d;
    logic [SW-1:0]                  n_sum;
    logic [LW-1:0]                  n_span;
    logic [LW:0]                    n_k;
    logic                           n_over;
    logic [LW-1:0]                  n_adj;
    logic [LW:0]                    n_nsp_sum;
    logic                           out_free;
    logic                           out_load;

    assign out_free = !r_out_valid || i_out_ready;
    // The output register takes a new sample in this cycle.
    assign out_load = out_free && ((r_state == ST_PASS) || (r_state == ST_EMIT));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_d      = {r_cur[a][arl_pkg::COORD_W-1], r_cur[a]}
                     - {r_prev[a][arl_pkg::COORD_W-1], r_prev[a]};
            n_neg[a] = n_d[arl_pkg::MAG_W-1];
            n_mag[a] = n_neg[a] ? (~n_d + arl_pkg::MAG_W'(1)) : n_d;
        end
        n_sum     = SW'(r_lsf) + SW'(seg_len);
        n_span    = r_next_len - r_lsf;
        n_k       = {1'b0, div_quo} + (LW + 1)'(div_rem != '0);
        n_over    = n_k > (LW + 1)'(MAX_SAMPLES_PER_SEGMENT);
        n_adj     = (div_rem != '0) ? (LW'(r_spacing) - div_rem) : '0;
        n_nsp_sum = {1'b0, r_next_len} + {1'b0, n_adj};
    end

    // Divider use: the sample count in ST_CHK, the weight of each sample later.
    always_comb begin
        seg_start = (r_state == ST_DECIDE) && (r_spacing != '0)
                 && !r_first && r_started;
        div_load  = 1'b0;
        div_rem0  = '0;
        div_num   = '0;
        div_den   = n_span;
        div_steps = DCW'(arl_pkg::WFRAC);
        lerp_clr  = 1'b0;
        unique case (r_state)
            ST_CHK: begin
                div_load  = (n_span != '0) && (r_nsp < r_next_len);
                div_num   = r_next_len - r_nsp;
                div_den   = LW'(r_spacing);
                div_steps = DCW'(LW);
            end
            ST_PLAN: begin
                div_load = 1'b1;
                div_rem0 = r_nsp - r_lsf;
                lerp_clr = 1'b1;
            end
            ST_EMIT: begin
                div_load = out_free && (r_cnt != CW'(1));
                div_rem0 = r_off + LW'(r_spacing);
                lerp_clr = div_load;
            end
            default: begin
            end
        endcase
    end

    arl_seglen u_seglen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seg_start),
        .i_mag_x (n_mag[0]),
        .i_mag_y (n_mag[1]),
        .i_mag_z (n_mag[2]),
        .o_stat  (seg_stat),
        .o_len   (seg_len)
    );

    arl_div #(.W(LW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_rem0  (div_rem0),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_stat  (div_stat),
        .o_step  (div_step),
        .o_qbit  (div_qbit),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    arl_lerp u_lerp (
        .i_clk  (i_clk),
        .i_clr  (lerp_clr),
        .i_step (div_step && (r_state == ST_WDIV)),
        .i_qbit (div_qbit),
        .i_mag  (r_mag),
        .i_neg  (r_neg),
        .i_base (r_prev),
        .o_pt   (lerp_pt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_spacing   <= arl_pkg::SPACING_RESET;
            r_started   <= 1'b0;
            r_lsf       <= '0;
            r_nsp       <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_spacing <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cur[0] <= i_point_x;
                        r_cur[1] <= i_point_y;
                        r_cur[2] <= i_point_z;
                        r_first  <= i_first_point;
                        r_state  <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_spacing == '0) begin
                        r_state <= ST_PASS;
                    end else if (r_first || !r_started) begin
                        r_prev    <= r_cur;
                        r_lsf     <= '0;
                        r_nsp     <= '0;
                        r_started <= 1'b1;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_mag   <= n_mag;
                        r_neg   <= n_neg;
                        r_state <= ST_LEN;
                    end
                end
                ST_PASS: begin
                    if (out_free) begin
                        r_out       <= r_cur;
                        r_out_last  <= 1'b1;
                        r_out_trunc <= 1'b0;
                        r_prev      <= r_cur;
                        r_lsf       <= '0;
                        r_nsp       <= '0;
                        r_started   <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_LEN: begin
                    if (seg_stat.done) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // Arc length at the segment end, saturated.
                    r_next_len <= (n_sum > LEN_MAX_X) ? LEN_MAX : LW'(n_sum);
                    r_state    <= ST_CHK;
                end
                ST_CHK: begin
                    r_hit   <= div_load;
                    r_state <= div_load ? ST_KDIV : ST_FIN;
                end
                ST_KDIV: begin
                    if (div_stat.done) begin
                        r_state <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    r_trunc   <= n_over;
                    r_cnt     <= n_over ? CW'(MAX_SAMPLES_PER_SEGMENT) : CW'(n_k);
                    r_nsp_new <= n_nsp_sum[LW] ? LEN_MAX : n_nsp_sum[LW-1:0];
                    r_off     <= div_rem0;
                    r_state   <= ST_WDIV;
                end
                ST_WDIV: begin
                    if (div_stat.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out       <= lerp_pt;
                        r_out_last  <= (r_cnt == CW'(1));
                        r_out_trunc <= r_trunc;
                        r_cnt       <= r_cnt - CW'(1);
                        r_off       <= div_rem0;
                        r_state     <= (r_cnt == CW'(1)) ? ST_FIN : ST_WDIV;
                    end
                end
                ST_FIN: begin
                    r_prev  <= r_cur;
                    r_lsf   <= r_next_len;
                    if (r_hit) begin
                        r_nsp <= r_nsp_new;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_sample_x      = r_out[0];
    assign o_sample_y      = r_out[1];
    assign o_sample_z      = r_out[2];
    assign o_last_of_run   = r_out_last;
    assign o_run_truncated = r_out_trunc;

endmodule

>>> src/arl_checker.sv
// Port-level checker for the resampler core, with its bind statement.
// Depends on polyline_arc_length_resampler_core_defines.svh.
`include "polyline_arc_length_resampler_core_defines.svh"

module arl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_sample_x,
    input logic [31:0] o_sample_y,
    input logic [31:0] o_sample_z,
    input logic        o_last_of_run,
    input logic        o_run_truncated
);
    // A stalled sample holds its value.
    `ARL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample_x) && $stable(o_sample_y) && $stable(o_sample_z) && $stable(o_last_of_run) && $stable(o_run_truncated), "stalled sample changed")

    // Reset empties the output register.
    `ARL_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    // One vertex at a time: a taken vertex closes the input.
    `ARL_ASSERT_NEXT(a_one_vertex, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input open after a vertex transaction")

    // While a vertex still owes samples, no new vertex is taken.
    `ARL_ASSERT_NOW(a_run_open, i_clk, i_rst_n, o_out_valid && !o_last_of_run, !o_in_ready, "input open in the middle of a run")

endmodule

bind polyline_arc_length_resampler_core arl_checker u_arl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_sample_x      (o_sample_x),
    .o_sample_y      (o_sample_y),
    .o_sample_z      (o_sample_z),
    .o_last_of_run   (o_last_of_run),
    .o_run_truncated (o_run_truncated)
);
